>>> sv/fkw_pkg.sv
package fkw_pkg;

  localparam int TOK_W = 16;
  localparam int PCT_W = 7;
  localparam int WIU_W = 6;
  localparam int ENTRY_W = 5;
  localparam int BYTE_W = 8;
  localparam int ACT_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CMP_W = 23;

  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TEXT   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_END    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_PERCENT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_USE  = 1'd1;

  localparam logic [PCT_W-1:0] PERCENT_RESET = 7'd80;
  localparam logic [CMP_W-1:0] PERCENT_SCALE = 23'd100;
  localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;
  localparam logic [TOK_W-1:0] TOKEN_LEN_MAX = 16'hFFFF;

  // control and shared data broadcast from the sequencer to every cell
  typedef struct packed {
    logic                clear_entry;
    logic                append;
    logic                compare;
    logic                clear_hits;
    logic                chain_clear;
    logic                chain_shift;
    logic [ENTRY_W-1:0]  entry;
    logic [BYTE_W-1:0]   data_byte;
    logic [TOK_W-1:0]    tok_len;
    logic [PCT_W-1:0]    pct;
  } cell_ctl_t;

  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

>>> sv/fkw_cell.sv
module fkw_cell #(
  parameter int IDX = 0,
  parameter int MAX_WORD = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fkw_pkg::cell_ctl_t   ctl,
  input  logic                 in_use,
  input  logic                 chain_in,
  output logic                 chain_out
);

  localparam int AW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int LW = $clog2(MAX_WORD + 1);
  localparam int TW = fkw_pkg::TOK_W;
  localparam int CW = fkw_pkg::CMP_W;

  logic [fkw_pkg::BYTE_W-1:0] store [MAX_WORD];
  logic [fkw_pkg::BYTE_W-1:0] rd_data;
  logic [LW-1:0] len;
  logic [LW-1:0] hits;
  logic          selected;
  logic          tok_lt;
  logic [TW-1:0] len_ext;
  logic [TW-1:0] longer;
  logic [CW-1:0] have;
  logic [CW-1:0] need;
  logic          match;

  assign selected = (32'(ctl.entry) == IDX);
  assign len_ext  = TW'(len);
  assign tok_lt   = ctl.tok_len < len_ext;
  assign longer   = (ctl.tok_len > len_ext) ? ctl.tok_len : len_ext;
  assign have     = CW'(hits) * fkw_pkg::PERCENT_SCALE;
  assign need     = CW'(ctl.pct) * CW'(longer);

  always_comb begin
    match = 1'b0;
    if (in_use && longer != '0) begin
      if (len_ext == ctl.tok_len && hits == len) begin
        match = 1'b1;
      end else if (have >= need) begin
        match = 1'b1;
      end
    end
  end

  // word bytes, read at the current token position
  always_ff @(posedge clk) begin
    if (ctl.append && selected && len < LW'(MAX_WORD)) begin
      store[len[AW-1:0]] <= ctl.data_byte;
    end
    rd_data <= store[ctl.tok_len[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      hits      <= '0;
      chain_out <= 1'b0;
    end else begin
      if (ctl.clear_entry && selected) begin
        len <= '0;
      end else if (ctl.append && selected && len < LW'(MAX_WORD)) begin
        len <= len + 1'b1;
      end
      if (ctl.clear_hits) begin
        hits <= '0;
      end else if (ctl.compare && tok_lt &&
                   fkw_pkg::fold_case(rd_data) == fkw_pkg::fold_case(ctl.data_byte)) begin
        hits <= hits + 1'b1;
      end
      if (ctl.chain_clear) begin
        chain_out <= 1'b0;
      end else if (ctl.chain_shift) begin
        chain_out <= chain_in | match;
      end
    end
  end

endmodule

>>> sv/fuzzy_keyword_spotter.sv
// channel  direction  fields (low bit up)
// s_*      in         action[1:0], entry[6:2], data_byte[14:7], zero [15]
// m_*      out        positive[0], zero [7:1]
// cfg_*    in         index 0 similarity_percent, index 1 words_in_use
//
// clear and append: applied to the selected cell on acceptance
// text byte other than space: cell store read, then compare in ST_CMP
// token close: ST_CLEAR, then ST_SWEEP while the match flag ripples down the cell chain, then ST_TALLY
// end of text adds ST_FINISH, which waits there while the result word is not taken
// rst is synchronous; the dictionary bytes are undefined until appended
module fuzzy_keyword_spotter #(
  parameter int NUM_WORDS = 32,
  parameter int MAX_WORD = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // action, entry, data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // positive
  input  logic        cfg_we,
  input  logic [fkw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fkw_pkg::PCT_W-1:0]     cfg_data
);

  localparam int CNT_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int TW = fkw_pkg::TOK_W;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CMP    = 6'b000010,
    ST_CLEAR  = 6'b000100,
    ST_SWEEP  = 6'b001000,
    ST_TALLY  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [fkw_pkg::ACT_W-1:0]   in_action;
  logic [fkw_pkg::ENTRY_W-1:0] in_entry;
  logic [fkw_pkg::BYTE_W-1:0]  in_byte;

  logic [TW-1:0]                token_length;
  logic                         text_hit;
  logic                         end_pending;
  logic [CNT_W-1:0]             count;
  logic [fkw_pkg::PCT_W-1:0]    pct;
  logic [fkw_pkg::WIU_W-1:0]    words_in_use;
  logic [fkw_pkg::BYTE_W-1:0]   byte_reg;
  logic                         positive;
  logic                         accept;
  logic                         out_free;

  fkw_pkg::cell_ctl_t ctl;
  logic [NUM_WORDS:0]   chain;
  logic [NUM_WORDS-1:0] in_use;

  assign in_action = s_tdata[1:0];
  assign in_entry  = s_tdata[6:2];
  assign in_byte   = s_tdata[14:7];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {7'd0, positive};

  always_comb begin
    ctl = '0;
    ctl.entry     = in_entry;
    ctl.data_byte = (state == ST_CMP) ? byte_reg : in_byte;
    ctl.tok_len   = token_length;
    ctl.pct       = pct;
    ctl.compare     = (state == ST_CMP);
    ctl.chain_clear = (state == ST_CLEAR);
    ctl.chain_shift = (state == ST_SWEEP);
    ctl.clear_hits  = (state == ST_TALLY);
    if (accept) begin
      ctl.clear_entry = (in_action == fkw_pkg::ACT_CLEAR);
      ctl.append      = (in_action == fkw_pkg::ACT_APPEND);
    end
  end

  assign chain[0] = 1'b0;

  for (genvar i = 0; i < NUM_WORDS; i++) begin : g_cell
    assign in_use[i] = (32'(words_in_use) > i);
    fkw_cell #(
      .IDX(i),
      .MAX_WORD(MAX_WORD)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .ctl(ctl),
      .in_use(in_use[i]),
      .chain_in(chain[i]),
      .chain_out(chain[i+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_action)
            fkw_pkg::ACT_TEXT: begin
              state_next = (in_byte == fkw_pkg::SPACE_BYTE) ? ST_CLEAR : ST_CMP;
            end
            fkw_pkg::ACT_END: begin
              state_next = (token_length != '0) ? ST_CLEAR : ST_FINISH;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_CMP:    state_next = ST_IDLE;
      ST_CLEAR:  state_next = ST_SWEEP;
      ST_SWEEP: begin
        if (count == CNT_W'(NUM_WORDS - 1)) begin
          state_next = ST_TALLY;
        end
      end
      ST_TALLY:  state_next = end_pending ? ST_FINISH : ST_IDLE;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_reg <= in_byte;
    end
    if (state == ST_FINISH && out_free) begin
      positive <= text_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      token_length <= '0;
      text_hit     <= 1'b0;
      end_pending  <= 1'b0;
      count        <= '0;
      pct          <= fkw_pkg::PERCENT_RESET;
      words_in_use <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          fkw_pkg::REG_PERCENT: pct <= cfg_data;
          fkw_pkg::REG_IN_USE:  words_in_use <= fkw_pkg::WIU_W'(cfg_data);
          default: ;
        endcase
      end
      if (accept) begin
        end_pending <= (in_action == fkw_pkg::ACT_END);
      end
      if (state == ST_CMP && token_length != fkw_pkg::TOKEN_LEN_MAX) begin
        token_length <= token_length + 1'b1;
      end
      // the last cell holds the or of every cell once the sweep is through
      if (state == ST_CLEAR) begin
        count <= '0;
      end else if (state == ST_SWEEP) begin
        count <= count + 1'b1;
      end
      if (state == ST_TALLY) begin
        token_length <= '0;
        if (chain[NUM_WORDS]) begin
          text_hit <= 1'b1;
        end
      end
      if (state == ST_FINISH && out_free) begin
        m_tvalid     <= 1'b1;
        text_hit     <= 1'b0;
        token_length <= '0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

>>> dv/fkw_checker.sv
module fkw_checker #(
  parameter int NUM_WORDS = 32,
  parameter int MAX_WORD = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // action, entry, data_byte
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [7:0]                    m_tdata,   // positive
  input  logic                          cfg_we,
  input  logic [fkw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fkw_pkg::PCT_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            outstanding
);

  logic [fkw_pkg::BYTE_W-1:0] dict_bytes [NUM_WORDS][MAX_WORD];
  logic [4:0]                 dict_len [NUM_WORDS];
  logic [4:0]                 pos_hits [NUM_WORDS];
  logic [fkw_pkg::TOK_W-1:0]  tok_len;
  logic                       any_hit;
  logic [fkw_pkg::PCT_W-1:0]  pct_reg;
  logic [fkw_pkg::WIU_W-1:0]  in_use_reg;

  bit                expected_positive [$];
  int                err_count = 0;
  bit                want;

  function automatic logic [fkw_pkg::BYTE_W-1:0] lower_ascii(
      input logic [fkw_pkg::BYTE_W-1:0] b);
    if (b >= "A" && b <= "Z") begin
      return b + 8'h20;
    end
    return b;
  endfunction

  function automatic bit token_matches_dictionary();
    int limit;
    int longer;
    limit = (int'(in_use_reg) < NUM_WORDS) ? int'(in_use_reg) : NUM_WORDS;
    for (int w = 0; w < limit; w++) begin
      longer = (int'(tok_len) > int'(dict_len[w])) ? int'(tok_len) : int'(dict_len[w]);
      if (longer != 0) begin
        if (int'(dict_len[w]) == int'(tok_len) && pos_hits[w] == dict_len[w]) begin
          return 1'b1;
        end
        // percent threshold as a cross-multiply, no rounding
        if (int'(pos_hits[w]) * int'(fkw_pkg::PERCENT_SCALE) >= int'(pct_reg) * longer) begin
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void close_token();
    if (token_matches_dictionary()) begin
      any_hit = 1'b1;
    end
    tok_len = '0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      pos_hits[w] = '0;
    end
  endfunction

  function automatic void take_word(input logic [fkw_pkg::ACT_W-1:0] act,
                                    input logic [fkw_pkg::ENTRY_W-1:0] ent,
                                    input logic [fkw_pkg::BYTE_W-1:0] val);
    case (act)
      fkw_pkg::ACT_CLEAR: begin
        dict_len[ent] = '0;
      end
      fkw_pkg::ACT_APPEND: begin
        // bytes past the word limit are dropped
        if (int'(dict_len[ent]) < MAX_WORD) begin
          dict_bytes[ent][dict_len[ent]] = val;
          dict_len[ent] = dict_len[ent] + 5'd1;
        end
      end
      fkw_pkg::ACT_TEXT: begin
        if (val == fkw_pkg::SPACE_BYTE) begin
          close_token();
        end else begin
          for (int w = 0; w < NUM_WORDS; w++) begin
            if (int'(tok_len) < int'(dict_len[w])) begin
              if (lower_ascii(val) == lower_ascii(dict_bytes[w][tok_len])) begin
                pos_hits[w] = pos_hits[w] + 5'd1;
              end
            end
          end
          if (tok_len != fkw_pkg::TOKEN_LEN_MAX) begin
            tok_len = tok_len + 16'd1;
          end
        end
      end
      default: begin
        // an empty last token is skipped
        if (tok_len != '0) begin
          close_token();
        end
        expected_positive.insert(expected_positive.size(), any_hit);
        any_hit = 1'b0;
        tok_len = '0;
        for (int w = 0; w < NUM_WORDS; w++) begin
          pos_hits[w] = '0;
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        dict_len[w] = '0;
        pos_hits[w] = '0;
      end
      tok_len = '0;
      any_hit = 1'b0;
      pct_reg = fkw_pkg::PERCENT_RESET;
      in_use_reg = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_positive.size() == 0) begin
          err_count++;
          $error("unexpected result word, positive %0d", m_tdata[0]);
        end else begin
          want = expected_positive.pop_front();
          if (m_tdata[0] !== want) begin
            err_count++;
            $error("positive: expected %0d, got %0d", want, m_tdata[0]);
          end
          if (m_tdata[7:1] !== 7'd0) begin
            err_count++;
            $error("padding: expected 0, got %0h", m_tdata[7:1]);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          fkw_pkg::REG_PERCENT: pct_reg = cfg_data;
          fkw_pkg::REG_IN_USE:  in_use_reg = cfg_data[fkw_pkg::WIU_W-1:0];
          default:     ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        take_word(s_tdata[1:0], s_tdata[6:2], s_tdata[14:7]);
      end
    end
    mismatches <= err_count;
    outstanding <= expected_positive.size();
  end

endmodule

>>> dv/tb_fuzzy_keyword_spotter.sv
module tb_fuzzy_keyword_spotter;

  localparam int NUM_WORDS = 32;
  localparam int MAX_WORD = 16;
  localparam int CLK_PERIOD = 12;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS = 900;
  localparam int TIMEOUT_CYCLES = 2000000;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [15:0]                   s_tdata;   // action, entry, data_byte
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [7:0]                    m_tdata;   // positive
  logic                          cfg_we;
  logic [fkw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fkw_pkg::PCT_W-1:0]     cfg_data;
  int                            mismatches;
  int                            outstanding;

  int                   item_count = 0;
  int                   burst_left = 0;
  int                   rx_left = 0;
  int                   rx_mode = 0;
  int                   rx_hold = 0;

  // local copy of the dictionary, used only to shape tokens
  logic [fkw_pkg::BYTE_W-1:0] dict_copy [NUM_WORDS][MAX_WORD];
  int                         dict_copy_len [NUM_WORDS];

  fuzzy_keyword_spotter #(
    .NUM_WORDS(NUM_WORDS),
    .MAX_WORD(MAX_WORD)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  fkw_checker #(
    .NUM_WORDS(NUM_WORDS),
    .MAX_WORD(MAX_WORD)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: switches at random among four ready modes, one of them never stalls
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 300);
    end
    rx_left--;
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 5) == 0);
      default: begin
        if (rx_hold == 0) begin
          rx_hold = $urandom_range(1, 40);
        end
        rx_hold--;
        m_tready <= (rx_hold == 0);
      end
    endcase
  end

  function automatic logic [fkw_pkg::BYTE_W-1:0] word_letter();
    logic [fkw_pkg::BYTE_W-1:0] base;
    base = ($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61;
    return base + 8'($urandom_range(0, 7));
  endfunction

  task automatic push(input logic [fkw_pkg::ACT_W-1:0] act,
                      input logic [fkw_pkg::ENTRY_W-1:0] ent,
                      input logic [fkw_pkg::BYTE_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 3))
        0: gap = 0;
        1: gap = $urandom_range(1, 3);
        2: gap = $urandom_range(4, 20);
        default: gap = 1;
      endcase
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, val, ent, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    item_count++;
    burst_left--;
  endtask

  // block idle: nothing pending and any token close has run through
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_regs(input int pct, input int in_use);
    cfg_we <= 1'b1;
    cfg_index <= fkw_pkg::REG_PERCENT;
    cfg_data <= fkw_pkg::PCT_W'(pct);
    @(posedge clk);
    cfg_index <= fkw_pkg::REG_IN_USE;
    cfg_data <= fkw_pkg::PCT_W'(in_use);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_word(input int e, input int n);
    logic [fkw_pkg::BYTE_W-1:0] b;
    push(fkw_pkg::ACT_CLEAR, fkw_pkg::ENTRY_W'(e), 8'($urandom));
    dict_copy_len[e] = 0;
    for (int i = 0; i < n; i++) begin
      b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : word_letter();
      push(fkw_pkg::ACT_APPEND, fkw_pkg::ENTRY_W'(e), b);
      if (dict_copy_len[e] < MAX_WORD) begin
        dict_copy[e][dict_copy_len[e]] = b;
        dict_copy_len[e]++;
      end
    end
  endtask

  // a token shaped after a stored word: case flips, substitutions, length changes
  task automatic send_token();
    int w;
    int base_len;
    int n;
    int e;
    logic [fkw_pkg::BYTE_W-1:0] b;
    w = $urandom_range(0, NUM_WORDS - 1);
    base_len = dict_copy_len[w];
    case ($urandom_range(0, 5))
      0: n = $urandom_range(1, 20);
      1: n = base_len + $urandom_range(1, 3);
      2: n = (base_len > 1) ? base_len - 1 : base_len;
      default: n = base_len;
    endcase
    for (int i = 0; i < n; i++) begin
      if (i < base_len && $urandom_range(0, 9) < 8) begin
        b = dict_copy[w][i];
        if (((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) && $urandom_range(0, 1) == 1) begin
          b = b ^ 8'h20;
        end
      end else if ($urandom_range(0, 7) == 0) begin
        b = 8'($urandom);
      end else begin
        b = word_letter();
      end
      push(fkw_pkg::ACT_TEXT, fkw_pkg::ENTRY_W'($urandom), b);
      // dictionary edit in the middle of a token
      if ($urandom_range(0, 15) == 0) begin
        e = $urandom_range(0, NUM_WORDS - 1);
        if ($urandom_range(0, 2) == 0) begin
          push(fkw_pkg::ACT_CLEAR, fkw_pkg::ENTRY_W'(e), 8'($urandom));
          dict_copy_len[e] = 0;
        end else begin
          b = word_letter();
          push(fkw_pkg::ACT_APPEND, fkw_pkg::ENTRY_W'(e), b);
          if (dict_copy_len[e] < MAX_WORD) begin
            dict_copy[e][dict_copy_len[e]] = b;
            dict_copy_len[e]++;
          end
        end
      end
    end
  endtask

  task automatic send_text();
    int ntok;
    ntok = $urandom_range(1, 5);
    if ($urandom_range(0, 7) == 0) begin
      push(fkw_pkg::ACT_TEXT, fkw_pkg::ENTRY_W'($urandom), fkw_pkg::SPACE_BYTE);
    end
    for (int t = 0; t < ntok; t++) begin
      send_token();
      if (t < ntok - 1 || $urandom_range(0, 3) == 0) begin
        push(fkw_pkg::ACT_TEXT, fkw_pkg::ENTRY_W'($urandom), fkw_pkg::SPACE_BYTE);
      end
      if ($urandom_range(0, 7) == 0) begin
        push(fkw_pkg::ACT_TEXT, fkw_pkg::ENTRY_W'($urandom), fkw_pkg::SPACE_BYTE);
      end
    end
    push(fkw_pkg::ACT_END, fkw_pkg::ENTRY_W'($urandom), 8'($urandom));
  endtask

  initial begin
    int stop_at;
    int pct;
    int in_use;
    int nload;
    bit first_phase;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= fkw_pkg::REG_PERCENT;
    cfg_data <= '0;
    for (int e = 0; e < NUM_WORDS; e++) begin
      dict_copy_len[e] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: case-folded exact match, spaces, extreme bytes and entries
    write_regs(fkw_pkg::PERCENT_RESET, NUM_WORDS);
    push(fkw_pkg::ACT_CLEAR, 5'd0, 8'h00);
    push(fkw_pkg::ACT_APPEND, 5'd0, "C");
    push(fkw_pkg::ACT_APPEND, 5'd0, "a");
    push(fkw_pkg::ACT_APPEND, 5'd0, "t");
    push(fkw_pkg::ACT_CLEAR, 5'd31, 8'hFF);
    push(fkw_pkg::ACT_APPEND, 5'd31, 8'hFF);
    push(fkw_pkg::ACT_APPEND, 5'd31, 8'h00);
    push(fkw_pkg::ACT_TEXT, 5'd0, fkw_pkg::SPACE_BYTE);
    push(fkw_pkg::ACT_TEXT, 5'd0, fkw_pkg::SPACE_BYTE);
    push(fkw_pkg::ACT_TEXT, 5'd0, "c");
    push(fkw_pkg::ACT_TEXT, 5'd0, "A");
    push(fkw_pkg::ACT_TEXT, 5'd0, "t");
    push(fkw_pkg::ACT_TEXT, 5'd0, fkw_pkg::SPACE_BYTE);
    push(fkw_pkg::ACT_END, 5'd0, 8'h00);
    push(fkw_pkg::ACT_TEXT, 5'd31, "c");
    push(fkw_pkg::ACT_TEXT, 5'd31, "a");
    push(fkw_pkg::ACT_TEXT, 5'd31, "x");
    push(fkw_pkg::ACT_END, 5'd31, 8'hFF);
    push(fkw_pkg::ACT_TEXT, 5'd0, 8'hFF);
    push(fkw_pkg::ACT_TEXT, 5'd0, 8'h00);
    push(fkw_pkg::ACT_END, 5'd0, 8'h00);
    // zero threshold: an empty token matches any nonempty word
    drain();
    write_regs(0, NUM_WORDS);
    push(fkw_pkg::ACT_TEXT, 5'd0, fkw_pkg::SPACE_BYTE);
    push(fkw_pkg::ACT_END, 5'd0, 8'h00);
    // threshold above 100 with an oversized word count: exact only
    drain();
    write_regs(127, 63);
    push(fkw_pkg::ACT_TEXT, 5'd0, "C");
    push(fkw_pkg::ACT_TEXT, 5'd0, "A");
    push(fkw_pkg::ACT_TEXT, 5'd0, "t");
    push(fkw_pkg::ACT_END, 5'd0, 8'h00);

    stop_at = item_count + RANDOM_ITEMS;
    first_phase = 1'b1;
    while (item_count < stop_at) begin
      drain();
      case ($urandom_range(0, 9))
        0: pct = 0;
        1: pct = 100;
        2: pct = $urandom_range(101, 127);
        3: pct = 127;
        default: pct = $urandom_range(40, 95);
      endcase
      case ($urandom_range(0, 7))
        0: in_use = 0;
        1: in_use = 63;
        2: in_use = $urandom_range(33, 62);
        default: in_use = $urandom_range(8, 32);
      endcase
      write_regs(pct, in_use);
      nload = first_phase ? NUM_WORDS : $urandom_range(0, 6);
      for (int k = 0; k < nload; k++) begin
        case ($urandom_range(0, 7))
          0: load_word(first_phase ? k : $urandom_range(0, NUM_WORDS - 1), 0);
          1: load_word(first_phase ? k : $urandom_range(0, NUM_WORDS - 1),
                       $urandom_range(MAX_WORD, MAX_WORD + 2));
          default: load_word(first_phase ? k : $urandom_range(0, NUM_WORDS - 1),
                             $urandom_range(1, 8));
        endcase
      end
      first_phase = 1'b0;
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 3)) push(2'($urandom), 5'($urandom), 8'($urandom));
        end
        send_text();
      end
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
